// File: rtl/core/path_step_parser_assert.svh
// Assertion helpers; expect clk and rst in scope at the point of use.
`ifndef PATH_STEP_PARSER_ASSERT_SVH
`define PATH_STEP_PARSER_ASSERT_SVH

// Same-cycle implication.
`define PSP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define PSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/pathp_pkg.sv
package pathp_pkg;

  localparam int DigitLimitDefault = 11;
  localparam int DigitCountW = 5;
  localparam int IdW = 32;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [1:0] KIND_STEP    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [IdW-1:0]         accum_value;
    logic [DigitCountW-1:0] digit_count;
    logic                   field_stopped;
    logic [IdW-1:0]         step_counter;
    logic                   error_seen;
  } state_t;

  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] step_index;
    logic [IdW-1:0] vertex_id;
    logic           is_reverse;
    logic [IdW-1:0] step_total;
    logic           last_result;
  } result_t;

endpackage

// File: rtl/core/pathp_in_if.sv
interface pathp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_path;

  modport source (output valid, output char_byte, output end_of_path, input ready);
  modport sink (input valid, input char_byte, input end_of_path, output ready);
endinterface

// File: rtl/core/pathp_out_if.sv
interface pathp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] step_index;
  logic [31:0] vertex_id;
  logic        is_reverse;
  logic [31:0] step_total;
  logic        last_result;

  modport source (output valid, output kind, output step_index, output vertex_id,
                  output is_reverse, output step_total, output last_result,
                  input ready);
  modport sink (input valid, input kind, input step_index, input vertex_id,
                input is_reverse, input step_total, input last_result,
                output ready);
endinterface

// File: rtl/core/pathp_decode.sv
module pathp_decode #(
  parameter int DIGIT_LIMIT = pathp_pkg::DigitLimitDefault
) (
  input  pathp_pkg::state_t  state,
  input  logic [7:0]         char_byte,
  input  logic               end_of_path,
  output pathp_pkg::state_t  state_next,
  output logic               res_a_valid,
  output pathp_pkg::result_t res_a,
  output logic               res_b_valid,
  output pathp_pkg::result_t res_b
);
  import pathp_pkg::*;

  localparam logic [DigitCountW-1:0] Limit = DigitCountW'(DIGIT_LIMIT);

  state_t          upd;
  logic            pre_valid;
  result_t         pre_res;
  result_t         summary;
  logic [IdW+3:0]  prod;
  logic [3:0]      digit;
  logic            is_digit;

  assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
  assign digit    = 4'(char_byte - CHAR_ZERO);
  // value*10 + digit as (v<<3) + (v<<1) + digit
  assign prod = ({4'b0, state.accum_value} << 3) + ({4'b0, state.accum_value} << 1)
              + {(IdW)'(0), digit};

  always_comb begin
    upd       = state;
    pre_valid = 1'b0;
    pre_res   = '0;
    if (char_byte == CHAR_COMMA) begin
      upd.step_counter  = state.step_counter + 1'b1;
      upd.accum_value   = '0;
      upd.digit_count   = '0;
      upd.field_stopped = 1'b0;
    end else if (!state.error_seen) begin
      if (char_byte == CHAR_PLUS || char_byte == CHAR_MINUS) begin
        pre_valid          = 1'b1;
        pre_res.kind       = KIND_STEP;
        pre_res.step_index = state.step_counter;
        pre_res.vertex_id  = state.accum_value;
        pre_res.is_reverse = (char_byte == CHAR_MINUS);
      end else begin
        if (is_digit) begin
          if (!state.field_stopped) begin
            upd.accum_value = (prod[IdW+3:IdW] != 4'd0) ? '1 : prod[IdW-1:0];
          end
        end else begin
          upd.field_stopped = 1'b1;
        end
        upd.digit_count = state.digit_count + 1'b1;
        if (upd.digit_count >= Limit) begin
          upd.error_seen     = 1'b1;
          pre_valid          = 1'b1;
          pre_res.kind       = KIND_ERROR;
          pre_res.step_index = state.step_counter;
        end
      end
    end
  end

  always_comb begin
    summary             = '0;
    summary.kind        = KIND_SUMMARY;
    summary.step_total  = upd.step_counter + 1'b1;
    summary.last_result = 1'b1;
  end

  // path end returns every field to reset
  assign state_next  = end_of_path ? '0 : upd;
  assign res_a_valid = pre_valid || end_of_path;
  assign res_a       = pre_valid ? pre_res : summary;
  assign res_b_valid = pre_valid && end_of_path;
  assign res_b       = summary;

endmodule

// File: rtl/core/pathp_queue.sv
module pathp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_a,
  input  pathp_pkg::result_t data_a,
  input  logic               push_b,
  input  pathp_pkg::result_t data_b,
  input  logic               pop,
  output logic               head_valid,
  output pathp_pkg::result_t head,
  output logic               room,
  output logic [pathp_pkg::QCntW-1:0] count
);
  import pathp_pkg::*;

  result_t          mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count_next;
  logic             do_pop;

  assign do_pop     = pop && head_valid;
  assign count_next = count + QCntW'(push_a) + QCntW'(push_b) - QCntW'(do_pop);

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr + 1'b1] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push_a) + QPtrW'(push_b);
      rd_ptr <= rd_ptr + QPtrW'(do_pop);
      count  <= count_next;
    end
  end

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  // an item may add two results
  assign room       = (count <= QCntW'(QDepth - 2));

endmodule

// File: rtl/core/path_step_parser.sv
// A byte is registered in the input stage, then its results in the result queue.
// Throughput: one byte per cycle while the result queue has room for two;
// a byte that yields two results (step or error plus the path summary) puts
// both into a four-entry result queue drained by the one-result output port.
// Reset (rst, synchronous): clears the parse state, input stage and result queue.
module path_step_parser #(
  parameter int DIGIT_LIMIT = pathp_pkg::DigitLimitDefault
) (
  input logic  clk,
  input logic  rst,
  pathp_in_if.sink    bytes,
  pathp_out_if.source steps
);
  import pathp_pkg::*;

  logic             in_v;
  logic [7:0]       in_char;
  logic             in_last;
  logic             advance;
  logic             room;
  state_t           state;
  state_t           state_next;
  logic             res_a_valid;
  logic             res_b_valid;
  result_t          res_a;
  result_t          res_b;
  logic             head_valid;
  result_t          head;
  logic [QCntW-1:0] q_count;

  assign advance     = in_v && room;
  assign bytes.ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (bytes.ready) begin
      in_v <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_char <= bytes.char_byte;
      in_last <= bytes.end_of_path;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  pathp_decode #(
    .DIGIT_LIMIT(DIGIT_LIMIT)
  ) u_decode (
    .state       (state),
    .char_byte   (in_char),
    .end_of_path (in_last),
    .state_next  (state_next),
    .res_a_valid (res_a_valid),
    .res_a       (res_a),
    .res_b_valid (res_b_valid),
    .res_b       (res_b)
  );

  pathp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_a     (advance && res_a_valid),
    .data_a     (res_a),
    .push_b     (advance && res_b_valid),
    .data_b     (res_b),
    .pop        (steps.ready),
    .head_valid (head_valid),
    .head       (head),
    .room       (room),
    .count      (q_count)
  );

  assign steps.valid       = head_valid;
  assign steps.kind        = head.kind;
  assign steps.step_index  = head.step_index;
  assign steps.vertex_id   = head.vertex_id;
  assign steps.is_reverse  = head.is_reverse;
  assign steps.step_total  = head.step_total;
  assign steps.last_result = head.last_result;

`include "path_step_parser_assert.svh"

  `PSP_ASSERT_IMPLIES(a_queue_bound, 1'b1, q_count <= QCntW'(QDepth))
  `PSP_ASSERT_IMPLIES(a_last_is_summary, steps.valid && steps.last_result, steps.kind == KIND_SUMMARY)
  `PSP_ASSERT_NEXT(a_path_end_reset, advance && in_last, state.step_counter == '0 && !state.error_seen)
  `PSP_ASSERT_IMPLIES(a_digit_bound, 1'b1, state.digit_count <= DigitCountW'(DIGIT_LIMIT))

endmodule
